// ===== rtl/core/srsw_pkg.sv =====
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared constants, types and helpers for the selective-repeat sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

  // Sequence space limit; fixed by the 3-bit number fields.
  localparam int unsigned SeqSpaceMax = 8;
  localparam int unsigned SeqW        = $clog2(SeqSpaceMax);
  localparam int unsigned WinMax      = SeqSpaceMax / 2;
  localparam int unsigned WinW        = SeqW;
  localparam int unsigned SpaceW      = SeqW + 1;
  localparam int unsigned TickW       = 8;

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CfgWindowSize   = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgTimeoutLimit = 1'd1;

  localparam logic [WinW-1:0]  WinSizeRst = 3'd4;
  localparam logic [TickW-1:0] LimitRst   = 8'd6;

  typedef struct packed {
    logic            en;
    logic [SeqW-1:0] addr;
    logic            data;
  } mark_wr_t;

  typedef struct packed {
    logic            en;
    logic [SeqW-1:0] addr;
  } mark_rd_t;

  // Clamp the window register to 1..WinMax.
  function automatic logic [WinW-1:0] eff_window(input logic [WinW-1:0] ws);
    logic [WinW-1:0] w;
    w = ws;
    if (ws == '0) begin
      w = WinW'(1);
    end else if (ws > WinW'(WinMax)) begin
      w = WinW'(WinMax);
    end
    return w;
  endfunction

  // Sequence space is twice the window.
  function automatic logic [SpaceW-1:0] seq_space(input logic [WinW-1:0] w);
    return {w, 1'b0};
  endfunction

  // Increment modulo the sequence space.
  function automatic logic [SeqW-1:0] seq_inc(input logic [SeqW-1:0]   x,
                                              input logic [SpaceW-1:0] s);
    logic [SpaceW-1:0] n;
    n = {1'b0, x} + SpaceW'(1);
    return (n == s) ? '0 : n[SeqW-1:0];
  endfunction

  // p is inside the window when p < s and (p - base) mod s < w.
  function automatic logic in_window(input logic [SeqW-1:0] p,
                                     input logic [SeqW-1:0] base,
                                     input logic [WinW-1:0] w);
    logic [SpaceW-1:0] s;
    logic [SpaceW-1:0] d;
    logic              hit;
    s   = seq_space(w);
    d   = {1'b0, p} + s - {1'b0, base};
    hit = 1'b0;
    if ({1'b0, p} < s) begin
      if (d >= s) begin
        d = d - s;
      end
      hit = (d < {1'b0, w});
    end
    return hit;
  endfunction

endpackage

// ===== rtl/core/srsw_mark_mem.sv =====
// ----------------------------------------------------------------------------
// srsw_mark_mem
// Acknowledgement mark store: 1-bit synchronous RAM with a registered read,
// per-entry valid flops so a window change clears the marks at once.
// ----------------------------------------------------------------------------
module srsw_mark_mem import srsw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     clear_i,
  input  mark_wr_t wr_i,
  input  mark_rd_t rd_i,
  output logic     rd_mark_o
);

  logic                   mem_q [SeqSpaceMax];
  logic [SeqSpaceMax-1:0] valid_q;
  logic                   rd_mark_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_mark_q <= mem_q[rd_i.addr] & valid_q[rd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  assign rd_mark_o = rd_mark_q;

endmodule

// ===== rtl/core/srsw_ctrl.sv =====
// ----------------------------------------------------------------------------
// srsw_ctrl
// Per-tick sequencer: mark update, base slide over the mark store, timeout
// and send decision, result register.
// ----------------------------------------------------------------------------
module srsw_ctrl import srsw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [WinW-1:0]   win_i,
  input  logic [TickW-1:0]  limit_i,
  input  logic              win_clear_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              ack_valid_i,
  input  logic [SeqW-1:0]   ack_number_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              send_valid_o,
  output logic [SeqW-1:0]   packet_number_o,
  output logic              retransmit_o,
  output logic              notice_o,
  output logic [SeqW-1:0]   window_base_o,
  output mark_wr_t          mark_wr_o,
  output mark_rd_t          mark_rd_o,
  input  logic              rd_mark_i
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StSlide = 2'd1;
  localparam logic [1:0] StTick  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [SeqW-1:0]   base_q, base_d;
  logic [SeqW-1:0]   next_q, next_d;
  logic [TickW-1:0]  tick_q, tick_d;
  logic              armed_q, armed_d;
  logic [SpaceW-1:0] guard_q, guard_d;
  logic              out_valid_q, out_valid_d;

  logic              o_send_q, o_send_d;
  logic [SeqW-1:0]   o_pkt_q, o_pkt_d;
  logic              o_resend_q, o_resend_d;
  logic              o_notice_q, o_notice_d;
  logic [SeqW-1:0]   o_base_q, o_base_d;

  logic [SpaceW-1:0] space;
  logic [SeqW-1:0]   base_inc;
  logic [TickW:0]    tick_inc;

  assign space    = seq_space(win_i);
  assign base_inc = seq_inc(base_q, space);
  assign tick_inc = {1'b0, tick_q} + (TickW+1)'(1);

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    next_d      = next_q;
    tick_d      = tick_q;
    armed_d     = armed_q;
    guard_d     = guard_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    o_send_d    = o_send_q;
    o_pkt_d     = o_pkt_q;
    o_resend_d  = o_resend_q;
    o_notice_d  = o_notice_q;
    o_base_d    = o_base_q;
    mark_wr_o   = '0;
    mark_rd_o   = '0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (ack_valid_i && (ack_number_i == base_q)) begin
            // base acknowledged: pass it now, then look at the next entries
            mark_wr_o = '{en: 1'b1, addr: base_q, data: 1'b0};
            mark_rd_o = '{en: 1'b1, addr: base_inc};
            base_d    = base_inc;
            guard_d   = SpaceW'(1);
            armed_d   = 1'b1;
            tick_d    = '0;
            state_d   = StSlide;
          end else begin
            if (ack_valid_i && in_window(ack_number_i, base_q, win_i)) begin
              mark_wr_o = '{en: 1'b1, addr: ack_number_i, data: 1'b1};
            end
            state_d = StTick;
          end
        end
      end
      StSlide: begin
        if (rd_mark_i && (guard_q < space)) begin
          mark_wr_o = '{en: 1'b1, addr: base_q, data: 1'b0};
          mark_rd_o = '{en: 1'b1, addr: base_inc};
          base_d    = base_inc;
          guard_d   = guard_q + SpaceW'(1);
        end else begin
          state_d = StTick;
        end
      end
      StTick: begin
        if (!out_valid_q || out_ready_i) begin
          o_send_d   = 1'b0;
          o_resend_d = 1'b0;
          o_notice_d = 1'b0;
          o_base_d   = base_q;
          if (tick_inc > {1'b0, limit_i}) begin
            // timeout: resend the base
            o_pkt_d    = base_q;
            o_send_d   = 1'b1;
            o_resend_d = 1'b1;
            tick_d     = '0;
          end else begin
            tick_d  = tick_inc[TickW] ? '1 : tick_inc[TickW-1:0];
            o_pkt_d = next_q;
            if (in_window(next_q, base_q, win_i)) begin
              o_send_d = 1'b1;
              next_d   = seq_inc(next_q, space);
            end else if (armed_q) begin
              o_notice_d = 1'b1;
              armed_d    = 1'b0;
            end
          end
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (win_clear_i) begin
      base_d  = '0;
      next_d  = '0;
      tick_d  = '0;
      armed_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      base_q      <= '0;
      next_q      <= '0;
      tick_q      <= '0;
      armed_q     <= 1'b1;
      guard_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      next_q      <= next_d;
      tick_q      <= tick_d;
      armed_q     <= armed_d;
      guard_q     <= guard_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    o_send_q   <= o_send_d;
    o_pkt_q    <= o_pkt_d;
    o_resend_q <= o_resend_d;
    o_notice_q <= o_notice_d;
    o_base_q   <= o_base_d;
  end

  assign in_ready_o      = (state_q == StIdle);
  assign out_valid_o     = out_valid_q;
  assign send_valid_o    = o_send_q;
  assign packet_number_o = o_pkt_q;
  assign retransmit_o    = o_resend_q;
  assign notice_o        = o_notice_q;
  assign window_base_o   = o_base_q;

endmodule

// ===== rtl/core/selective_repeat_sender_window.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Sender side of selective-repeat ARQ: window, ack marks, timeout resend.
// ----------------------------------------------------------------------------
// Usage
//   Each transfer on the slave stream is one tick. tuser[0] flags that an
//   acknowledgement came in, its number sits in tdata[2:0]. Every tick gives
//   exactly one transfer on the master stream: the packet sent (or refused),
//   whether it is a timeout resend, the window-full notice and the base.
//   Configuration: cfg_we_i with cfg_idx_i = 0 writes the window size
//   (clamped to 1..4) and restarts the window state; index 1 writes the
//   timeout limit. Write only while the block is idle.
// Sequence
//   A tick without a base acknowledgement is accepted, then the send
//   decision is made and the result registered. A base acknowledgement
//   adds slide steps, one per read of the mark RAM (registered read), while
//   the base passes further marked entries (at most window_size - 1). A new
//   tick is accepted only after the send decision of the last one.
// Reset
//   Window 4, limit 6, base and next number 0, marks clear, notice armed.
//   Marks are cleared through valid flops, so no clearing pass is needed.
// Stall
//   The result register holds while m_axis_tready is low; a new tick is
//   still accepted and worked up to the send decision, which waits for the
//   result register to free up.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window import srsw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // tick stream in
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [2:0] ack_number, [7:3] zero
  input  logic [0:0]          s_axis_tuser,  // [0] ack_valid
  // result stream out
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,  // [2:0] packet_number, [5:3] window_base,
                                             // [7:6] zero
  output logic [2:0]          m_axis_tuser   // [0] send_valid, [1] retransmit,
                                             // [2] window_full_notice
);

  logic [WinW-1:0]  win_size_q;
  logic [TickW-1:0] limit_q;
  logic [WinW-1:0]  win_eff;
  logic             win_clear;

  mark_wr_t         mark_wr;
  mark_rd_t         mark_rd;
  logic             rd_mark;

  logic             send_valid;
  logic [SeqW-1:0]  packet_number;
  logic             retransmit;
  logic             notice;
  logic [SeqW-1:0]  window_base;

  // Config registers; a window write also restarts the window state.
  assign win_clear = cfg_we_i && (cfg_idx_i == CfgWindowSize);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q <= WinSizeRst;
      limit_q    <= LimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWindowSize:   win_size_q <= cfg_wdata_i[WinW-1:0];
        CfgTimeoutLimit: limit_q    <= cfg_wdata_i[TickW-1:0];
        default:         ;
      endcase
    end
  end

  assign win_eff = eff_window(win_size_q);

  srsw_mark_mem u_mark_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (win_clear),
    .wr_i      (mark_wr),
    .rd_i      (mark_rd),
    .rd_mark_o (rd_mark)
  );

  srsw_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .win_i           (win_eff),
    .limit_i         (limit_q),
    .win_clear_i     (win_clear),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .ack_valid_i     (s_axis_tuser[0]),
    .ack_number_i    (s_axis_tdata[SeqW-1:0]),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .send_valid_o    (send_valid),
    .packet_number_o (packet_number),
    .retransmit_o    (retransmit),
    .notice_o        (notice),
    .window_base_o   (window_base),
    .mark_wr_o       (mark_wr),
    .mark_rd_o       (mark_rd),
    .rd_mark_i       (rd_mark)
  );

  assign m_axis_tdata = {2'b00, window_base, packet_number};
  assign m_axis_tuser = {notice, retransmit, send_valid};

endmodule

// ===== rtl/core/srsw_checker.sv =====
// ----------------------------------------------------------------------------
// srsw_checker
// Port-level checks on the sender window's result stream.
// ----------------------------------------------------------------------------
module srsw_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [2:0] m_axis_tuser
);

  // held result must not change under stall
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a resend is always a send
  a_resend_sends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("retransmit without send_valid");

  // a resend carries the base number
  a_resend_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[2:0] == m_axis_tdata[5:3])
    else $error("retransmit of a number other than the base");

  // the notice only comes with a refusal
  a_notice_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> !m_axis_tuser[0])
    else $error("window-full notice on a sent packet");

endmodule

bind selective_repeat_sender_window srsw_checker u_srsw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the selective-repeat sender window. A scoreboard
// class mirrors the window, the ack marks and the timeout counter, predicts
// one result per accepted tick and checks every result transfer in order.
// Directed ticks come first, then random phases over several window and
// timeout settings with varied back-pressure on both streams.
// ----------------------------------------------------------------------------
module testbench;
  import srsw_pkg::*;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  // One result transfer, unpacked from tdata/tuser.
  typedef struct packed {
    logic            send_valid;
    logic [SeqW-1:0] packet;
    logic            retransmit;
    logic            notice;
    logic [SeqW-1:0] base;
  } tick_result_t;

  // Window mirror: holds its own copy of the registers and window state and
  // queues the result each accepted tick should produce.
  class tick_scoreboard;
    logic [WinW-1:0]  win_reg;
    logic [TickW-1:0] limit_reg;
    logic [SeqW-1:0]  base_num;
    logic [SeqW-1:0]  next_num;
    bit               marks[SeqSpaceMax];
    int unsigned      ticks;
    bit               armed;
    tick_result_t     result_q[$];
    int unsigned      errors;

    function new();
      win_reg   = WinSizeRst;
      limit_reg = LimitRst;
      errors    = 0;
      clear_window();
    endfunction

    function void clear_window();
      base_num = '0;
      next_num = '0;
      foreach (marks[i]) marks[i] = 1'b0;
      ticks = 0;
      armed = 1'b1;
    endfunction

    // Register value 0 acts as 1, anything above half the space as the max.
    function int unsigned win_width();
      if (win_reg == '0) return 1;
      if (win_reg > WinMax) return WinMax;
      return 32'(win_reg);
    endfunction

    function int unsigned space();
      return 2 * win_width();
    endfunction

    function bit lies_in_window(int unsigned p);
      int unsigned w;
      int unsigned s;
      w = win_width();
      s = 2 * w;
      if (p >= s) return 1'b0;
      return ((p + s - base_num) % s) < w;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      if (idx == CfgWindowSize) begin
        win_reg = value[WinW-1:0];
        clear_window();
      end else if (idx == CfgTimeoutLimit) begin
        limit_reg = value[TickW-1:0];
      end
    endfunction

    function void note_tick(bit ack_valid, logic [SeqW-1:0] ack_num);
      int unsigned  s;
      int unsigned  t;
      int unsigned  guard;
      tick_result_t r;
      s = space();
      r = '0;
      if (ack_valid) begin
        if (lies_in_window(32'(ack_num))) marks[ack_num] = 1'b1;
        // base ack: slide over the marked run, re-arm, restart the counter
        if (ack_num == base_num) begin
          guard = 0;
          while (guard < s && marks[base_num]) begin
            marks[base_num] = 1'b0;
            base_num = SeqW'((base_num + 1) % s);
            guard++;
          end
          armed = 1'b1;
          ticks = 0;
        end
      end
      t = ticks + 1;
      if (t > limit_reg) begin
        r.packet     = base_num;
        r.retransmit = 1'b1;
        r.send_valid = 1'b1;
        ticks        = 0;
      end else begin
        ticks    = (t > 255) ? 255 : t;
        r.packet = next_num;
        if (lies_in_window(32'(next_num))) begin
          r.send_valid = 1'b1;
          next_num     = SeqW'((next_num + 1) % s);
        end else if (armed) begin
          r.notice = 1'b1;
          armed    = 1'b0;
        end
      end
      r.base = base_num;
      result_q.push_back(r);
    endfunction

    function void report_field(string name, logic [7:0] exp, logic [7:0] got);
      if (got !== exp) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, got);
        errors++;
      end
    endfunction

    function void check(tick_result_t got);
      tick_result_t exp;
      if (result_q.size() == 0) begin
        $display("%0t: result with no tick pending, expected none, actual %p",
                 $time, got);
        errors++;
        return;
      end
      exp = result_q.pop_front();
      report_field("send_valid", 8'(exp.send_valid), 8'(got.send_valid));
      report_field("packet_number", 8'(exp.packet), 8'(got.packet));
      report_field("retransmit", 8'(exp.retransmit), 8'(got.retransmit));
      report_field("window_full_notice", 8'(exp.notice), 8'(got.notice));
      report_field("window_base", 8'(exp.base), 8'(got.base));
    endfunction

    function int unsigned pending();
      return result_q.size();
    endfunction
  endclass

  // Directed ticks, {ack_valid, ack_number}, run at the reset setting
  // (window 4, limit 6): in-order sends, out-of-order marks, refusals,
  // acks outside the window, base slides over marked runs and a timeout.
  localparam logic [3:0] DIR_TICKS [24] = '{
    4'h7, 4'h0, 4'h0, 4'h0, 4'hA, 4'h9, 4'h0, 4'h0,
    4'h0, 4'hE, 4'h8, 4'hF, 4'hB, 4'h0, 4'h0, 4'h0,
    4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'hD, 4'hC
  };

  // Random phases: window register, timeout limit, idling, tick count.
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned PH_WIN   [NUM_PHASES] = '{1, 0, 7, 2, 3, 4, 5, 4};
  localparam int unsigned PH_LIMIT [NUM_PHASES] = '{1, 0, 255, 3, 10, 255, 2, 1};
  localparam int unsigned PH_TICKS [NUM_PHASES] = '{70, 50, 80, 70, 70, 60, 60, 60};
  localparam idle_mode_e  PH_IDLE  [NUM_PHASES] = '{
    IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE,
    IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE
  };
  localparam int unsigned PRESSURE_PHASE = 3;  // long receiver hold-off
  localparam int unsigned PAUSE_PHASE    = 4;  // sender waits for drain midway
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned SETTLE_CYCLES  = 8;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic [0:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic [2:0]          m_axis_tuser;

  tick_scoreboard sb;
  idle_mode_e     idle_mode = IDLE_NONE;
  bit             hold_req  = 1'b0;
  int unsigned    hold_left = 0;
  tick_result_t   mon_result;

  selective_repeat_sender_window dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Idle decision for one cycle on either stream under the current phase.
  function automatic bit idle_now(bit sender_side);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (idle_mode)
      IDLE_SEND: return sender_side && roll < 64;
      IDLE_RECV: return !sender_side && roll < 64;
      IDLE_BOTH: return roll < 19;
      default:   return 1'b0;
    endcase
  endfunction

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  // Offer one tick, with random sender gaps first; the scoreboard is told
  // at the edge where the transfer happens.
  task automatic send_tick(bit ack_valid, logic [SeqW-1:0] ack_num);
    @(negedge clk_i);
    while (idle_now(1'b1)) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(8 - SeqW){1'b0}}, ack_num};
    s_axis_tuser  <= ack_valid;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_tick(ack_valid, ack_num);
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // Block gives one result per tick, so an empty queue means idle; a wait of
  // SETTLE_CYCLES follows to cover the result register settling.
  task automatic wait_drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly well-formed traffic: acks of outstanding packets, base acks to
  // slide the window, plus plain ticks and stray ack numbers.
  task automatic pick_tick(output bit ack_valid, output logic [SeqW-1:0] ack_num);
    int unsigned roll;
    int unsigned s;
    int unsigned outstanding;
    roll        = $urandom_range(0, 99);
    s           = sb.space();
    outstanding = (sb.next_num + s - sb.base_num) % s;
    ack_valid   = 1'b1;
    if (roll < 15) begin
      ack_valid = 1'b0;
      ack_num   = SeqW'($urandom_range(0, SeqSpaceMax - 1));
    end else if (roll < 35 || outstanding == 0) begin
      ack_num = sb.base_num;
    end else if (roll < 80) begin
      ack_num = SeqW'((sb.base_num + $urandom_range(0, outstanding - 1)) % s);
    end else begin
      ack_num = SeqW'($urandom_range(0, SeqSpaceMax - 1));
    end
  endtask

  // Receiver: random stalls, or a long hold-off on request so that the
  // block backs up and stalls its input.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !idle_now(1'b0);
      end
    end
  end

  // Result monitor: sampled at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      mon_result.send_valid = m_axis_tuser[0];
      mon_result.retransmit = m_axis_tuser[1];
      mon_result.notice     = m_axis_tuser[2];
      mon_result.packet     = m_axis_tdata[SeqW-1:0];
      mon_result.base       = m_axis_tdata[2*SeqW-1:SeqW];
      sb.check(mon_result);
    end
  end

  initial begin
    bit              ack_valid;
    logic [SeqW-1:0] ack_num;
    sb = new();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed ticks at the reset setting, back-to-back
    idle_mode = IDLE_NONE;
    foreach (DIR_TICKS[i]) send_tick(DIR_TICKS[i][3], DIR_TICKS[i][2:0]);
    end_burst();
    wait_drain();

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      write_cfg(CfgWindowSize, CfgDataW'(PH_WIN[p]));
      write_cfg(CfgTimeoutLimit, CfgDataW'(PH_LIMIT[p]));
      idle_mode = PH_IDLE[p];
      if (p == PRESSURE_PHASE) hold_req = 1'b1;
      for (int unsigned i = 0; i < PH_TICKS[p]; i++) begin
        if (p == PAUSE_PHASE && i == PH_TICKS[p] / 2) begin
          end_burst();
          wait_drain();
        end
        pick_tick(ack_valid, ack_num);
        send_tick(ack_valid, ack_num);
      end
      end_burst();
      wait_drain();
    end

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
